@@ design/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants for the bilinear RGB image scaler
// Transaction payloads, command and register codes, and lerp arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  // Commands carried by an input transaction
  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_NEXT    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_TGT_W = 2'd2;
  localparam logic [1:0] REG_TGT_H = 2'd3;

  localparam int CFG_W   = 13;   // widest register
  localparam int SRC_W   = 8;    // source size register width
  localparam int TGT_W   = 13;   // target size register width
  localparam int ACC_W   = 33;   // accumulators never pass 2^33
  localparam int DIV_N   = 40;   // dividend width of step divisions
  localparam int DIV_CNT = 6;    // bits of the divider step counter
  localparam int NUM_LANES = 3;

  // Derived step slots
  localparam logic [2:0] ST_DX  = 3'd0;
  localparam logic [2:0] ST_DY  = 3'd1;
  localparam logic [2:0] ST_SX  = 3'd2;
  localparam logic [2:0] ST_SY  = 3'd3;
  localparam logic [2:0] ST_FX  = 3'd4;
  localparam logic [2:0] ST_FY  = 3'd5;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] red_in;
    logic [31:0] green_in;
    logic [31:0] blue_in;
  } in_t;

  typedef struct packed {
    logic [31:0] red_out;
    logic [31:0] green_out;
    logic [31:0] blue_out;
    logic        last;
  } out_t;

  // Controller to lane signals
  typedef struct packed {
    logic        wr_en;
    logic        rd_top;
    logic        consume;
    logic [31:0] fx;
    logic [31:0] fy;
  } lane_ctl_t;

  // Signed difference e - s of two unsigned words
  function automatic logic signed [32:0] sdiff(input logic [31:0] s, input logic [31:0] e);
    return $signed({1'b0, e}) - $signed({1'b0, s});
  endfunction

  // Bits 63:32 of f * d taken mod 2^64
  function automatic logic [31:0] mul_hi(input logic [31:0] f,
                                         input logic signed [32:0] d);
    logic signed [65:0] p;
    p = $signed({1'b0, f}) * d;
    return p[63:32];
  endfunction

endpackage

`default_nettype wire

@@ design/bilinear_rgb_image_scaler.sv @@
// ----------------------------------------------------------------------------
// bilinear_rgb_image_scaler: bilinear scaler for three-channel 32-bit pixels
// Three channel lanes interpolate side by side; this level merges them.
// Load and restart are taken without leaving the ready state. A next stalls
// the input until its pixel is emitted; each walker step adds to that stall,
// and a stalled output adds its stall. The first next of an image also runs
// six step divisions plus its first walk.
// Synchronous active-high reset clears control state; the pixel store is not
// cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_rgb_image_scaler #(
  parameter int MAX_SRC_WIDTH  = 128,
  parameter int MAX_SRC_HEIGHT = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire bis_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output bis_pkg::out_t                   out_data,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [bis_pkg::CFG_W-1:0]  cfg_data
);
  import bis_pkg::*;

  localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  lane_ctl_t       lane_ctl;
  logic [AW-1:0]   wr_addr, rd_addr_a, rd_addr_b;
  logic [31:0]     wr_data [NUM_LANES];
  logic [31:0]     result  [NUM_LANES];
  logic [NUM_LANES-1:0] done_vec;
  logic            out_free, emit, last;

  assign wr_data[0] = in_data.red_in;
  assign wr_data[1] = in_data.green_in;
  assign wr_data[2] = in_data.blue_in;
  assign out_free   = !out_valid || !out_stall;

  bis_ctrl #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .AW             (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .command    (in_data.command),
    .in_stall   (in_stall),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .lane_ctl   (lane_ctl),
    .wr_addr    (wr_addr),
    .rd_addr_a  (rd_addr_a),
    .rd_addr_b  (rd_addr_b),
    .lanes_done (&done_vec),
    .out_free   (out_free),
    .emit       (emit),
    .last       (last)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    bis_lane #(
      .DEPTH (DEPTH),
      .AW    (AW)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .ctl       (lane_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data[i]),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .result    (result[i]),
      .done      (done_vec[i])
    );
  end

  // Merge lane results into the output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.red_out   <= result[0];
      out_data.green_out <= result[1];
      out_data.blue_out  <= result[2];
      out_data.last      <= last;
    end
  end

endmodule

`default_nettype wire

@@ design/bis_div.sv @@
// ----------------------------------------------------------------------------
// bis_div: restoring divider, one quotient bit per cycle
// Returns the low 32 bits of the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bis_pkg::DIV_N-1:0]  dividend,
  input  wire logic [bis_pkg::TGT_W-1:0]  divisor,
  output logic                            done,
  output logic [31:0]                     quotient
);
  import bis_pkg::*;

  logic                busy;
  logic [DIV_CNT-1:0]  cnt;
  logic [TGT_W-1:0]    rem;
  logic [TGT_W-1:0]    dvs;
  logic [DIV_N-1:0]    num;
  logic [TGT_W:0]      sh;
  logic                ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    sh = {rem, num[DIV_N-1]};
    ge = (sh >= {1'b0, dvs});
  end

  // Sequence the shift and subtract steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      num <= dividend;
    end else if (busy) begin
      rem      <= ge ? TGT_W'(sh - {1'b0, dvs}) : sh[TGT_W-1:0];
      num      <= {num[DIV_N-2:0], 1'b0};
      quotient <= {quotient[30:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ design/bis_lane.sv @@
// ----------------------------------------------------------------------------
// bis_lane: one color channel lane
// Holds the channel plane and runs the x, x, y interpolation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_lane #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire bis_pkg::lane_ctl_t  ctl,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [31:0]         wr_data,
  input  wire logic [AW-1:0]       rd_addr_a,
  input  wire logic [AW-1:0]       rd_addr_b,
  output logic [31:0]              result,
  output logic                     done
);
  import bis_pkg::*;

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_a, rd_b;
  logic [4:0]  stg;
  logic [31:0] ph_top, ph_bot, ph_y;
  logic [31:0] s_top, s_bot, top, bot;
  logic [31:0] prod_x, prod_y;

  // Channel plane, two read ports
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

  always_comb begin
    prod_x = mul_hi(ctl.fx, sdiff(rd_a, rd_b));
    prod_y = mul_hi(ctl.fy, sdiff(top, bot));
  end

  // Advance stage flags and hold the finished result
  always_ff @(posedge clk) begin
    if (rst) begin
      stg  <= '0;
      done <= 1'b0;
    end else begin
      stg <= {stg[3:0], ctl.rd_top};
      if (stg[4]) begin
        done <= 1'b1;
      end else if (ctl.consume) begin
        done <= 1'b0;
      end
    end
  end

  // Interpolation pipeline
  always_ff @(posedge clk) begin
    if (stg[0]) begin
      ph_top <= prod_x;
      s_top  <= rd_a;
    end
    if (stg[1]) begin
      ph_bot <= prod_x;
      s_bot  <= rd_a;
      top    <= s_top + ph_top;
    end
    if (stg[2]) begin
      bot <= s_bot + ph_bot;
    end
    if (stg[3]) begin
      ph_y <= prod_y;
    end
    if (stg[4]) begin
      result <= top + ph_y;
    end
  end

endmodule

`default_nettype wire

@@ design/bis_ctrl.sv @@
// ----------------------------------------------------------------------------
// bis_ctrl: command decode, step computation and source cell traversal
// Walks the cells one step per cycle unless fetching or waiting, and drives the lane fetches.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_ctrl #(
  parameter int MAX_SRC_WIDTH  = 128,
  parameter int MAX_SRC_HEIGHT = 128,
  parameter int AW             = 14
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire bis_pkg::cmd_t              command,
  output logic                            in_stall,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [bis_pkg::CFG_W-1:0]  cfg_data,
  output bis_pkg::lane_ctl_t              lane_ctl,
  output logic [AW-1:0]                   wr_addr,
  output logic [AW-1:0]                   rd_addr_a,
  output logic [AW-1:0]                   rd_addr_b,
  input  wire logic                       lanes_done,
  input  wire logic                       out_free,
  output logic                            emit,
  output logic                            last
);
  import bis_pkg::*;

  localparam int STORE = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

  typedef enum logic [1:0] {PH_IDLE, PH_IN_ROW, PH_BETWEEN, PH_DONE} phase_t;
  typedef enum logic [2:0] {
    S_READY, S_DIV_GO, S_DIV_RUN, S_ADDR, S_RD_TOP, S_RD_BOT, S_FIND, S_WAIT
  } state_t;

  state_t          state;
  phase_t          phase;
  logic [SRC_W-1:0] src_w, src_h;
  logic [TGT_W-1:0] tgt_w, tgt_h;
  logic [AW:0]     load_count;
  logic [SRC_W-1:0] col, row;
  logic [ACC_W-1:0] xa0, xa1, ya0, ya1;
  logic [31:0]     frac_x, frac_y, pix_fx, pix_fy;
  logic [31:0]     step [6];
  logic [2:0]      div_k;
  logic            first;
  logic [16:0]     base;

  logic            accept, can_write;
  logic [SRC_W-1:0] eff_w, eff_h, nw, nh;
  logic [TGT_W-1:0] tw, th;
  logic [DIV_N-1:0] div_n;
  logic [TGT_W-1:0] div_d;
  logic            div_done;
  logic [31:0]     div_q;
  logic [SRC_W:0]  col_n, row_n;
  logic [16:0]     addr_row;

  // Effective sizes and division operands
  always_comb begin
    if (src_w < SRC_W'(2)) eff_w = SRC_W'(2);
    else if (32'(src_w) > MAX_SRC_WIDTH) eff_w = SRC_W'(MAX_SRC_WIDTH);
    else eff_w = src_w;
    if (src_h < SRC_W'(2)) eff_h = SRC_W'(2);
    else if (32'(src_h) > MAX_SRC_HEIGHT) eff_h = SRC_W'(MAX_SRC_HEIGHT);
    else eff_h = src_h;
    nw = eff_w - 1'b1;
    nh = eff_h - 1'b1;
    tw = (tgt_w == '0) ? TGT_W'(1) : tgt_w;
    th = (tgt_h == '0) ? TGT_W'(1) : tgt_h;
    div_n = DIV_N'(32'hFFFF_FFFF);
    div_d = tw;
    case (div_k)
      ST_DX: div_d = tw;
      ST_DY: div_d = th;
      ST_SX: div_d = TGT_W'(nw);
      ST_SY: div_d = TGT_W'(nh);
      ST_FX: begin
        div_n = {nw, 32'h0} - DIV_N'(nw);
        div_d = tw;
      end
      ST_FY: begin
        div_n = {nh, 32'h0} - DIV_N'(nh);
        div_d = th;
      end
      default: div_d = tw;
    endcase
  end

  // Handshake, lane control and fetch addresses
  always_comb begin
    accept    = in_valid && (state == S_READY);
    in_stall  = (state != S_READY);
    can_write = (load_count < (AW+1)'(STORE));
    col_n     = {1'b0, col} + 1'b1;
    row_n     = {1'b0, row} + 1'b1;
    addr_row  = (state == S_RD_TOP) ? base : base + 17'(eff_w);
    rd_addr_a = AW'(addr_row);
    rd_addr_b = AW'(addr_row + 17'd1);
    wr_addr   = load_count[AW-1:0];
    emit      = (state == S_WAIT) && lanes_done && out_free;
    last      = (phase == PH_DONE);
    lane_ctl.wr_en   = accept && (command == CMD_LOAD) && can_write;
    lane_ctl.rd_top  = (state == S_RD_TOP);
    lane_ctl.consume = emit;
    lane_ctl.fx      = pix_fx;
    lane_ctl.fy      = pix_fy;
  end

  bis_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIV_GO),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_READY;
      phase      <= PH_IDLE;
      load_count <= '0;
      src_w      <= SRC_W'(2);
      src_h      <= SRC_W'(2);
      tgt_w      <= TGT_W'(1);
      tgt_h      <= TGT_W'(1);
      first      <= 1'b0;
      div_k      <= '0;
    end else begin
      // Register writes return the phase to idle unless the walk sets it in that cycle
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SRC_W: src_w <= cfg_data[SRC_W-1:0];
          REG_SRC_H: src_h <= cfg_data[SRC_W-1:0];
          REG_TGT_W: tgt_w <= cfg_data[TGT_W-1:0];
          REG_TGT_H: tgt_h <= cfg_data[TGT_W-1:0];
        endcase
        phase <= PH_IDLE;
      end

      unique case (state)
        S_READY: begin
          if (accept) begin
            case (command)
              CMD_LOAD: begin
                if (can_write) load_count <= load_count + 1'b1;
              end
              CMD_RESTART: begin
                load_count <= '0;
                phase      <= PH_IDLE;
              end
              CMD_NEXT: begin
                if (phase == PH_IDLE) begin
                  div_k <= '0;
                  state <= S_DIV_GO;
                end else if (phase != PH_DONE) begin
                  state <= S_ADDR;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIV_GO: state <= S_DIV_RUN;
        S_DIV_RUN: begin
          if (div_done) begin
            step[div_k] <= div_q;
            if (div_k == ST_FY) begin
              row    <= '0;
              col    <= '0;
              ya0    <= '0;
              ya1    <= {1'b0, step[ST_SY]};
              xa0    <= '0;
              xa1    <= '0;
              frac_x <= '0;
              frac_y <= '0;
              phase  <= PH_BETWEEN;
              first  <= 1'b1;
              state  <= S_FIND;
            end else begin
              div_k <= div_k + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_ADDR: begin
          base   <= 17'(row) * 17'(eff_w) + 17'(col);
          pix_fx <= frac_x;
          pix_fy <= frac_y;
          frac_x <= frac_x + step[ST_FX];
          xa0    <= xa0 + {1'b0, step[ST_DX]};
          state  <= S_RD_TOP;
        end
        S_RD_TOP: state <= S_RD_BOT;
        S_RD_BOT: begin
          first <= 1'b0;
          state <= S_FIND;
        end
        S_FIND: begin
          if (phase == PH_IN_ROW) begin
            if (xa0 < xa1) begin
              // pending pixel found
              state <= first ? S_ADDR : S_WAIT;
            end else begin
              col <= col_n[SRC_W-1:0];
              if (col_n < {1'b0, nw}) begin
                xa1 <= xa1 + {1'b0, step[ST_SX]};
              end else begin
                phase  <= PH_BETWEEN;
                frac_y <= frac_y + step[ST_FY];
                ya0    <= ya0 + {1'b0, step[ST_DY]};
              end
            end
          end else if (ya0 < ya1) begin
            phase  <= PH_IN_ROW;
            col    <= '0;
            xa0    <= '0;
            xa1    <= {1'b0, step[ST_SX]};
            frac_x <= '0;
          end else begin
            row <= row_n[SRC_W-1:0];
            if (row_n >= {1'b0, nh}) begin
              phase <= PH_DONE;
              state <= first ? S_READY : S_WAIT;
            end else begin
              ya1 <= ya1 + {1'b0, step[ST_SY]};
            end
          end
        end
        S_WAIT: begin
          if (emit) state <= S_READY;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
